/* sv/md5_pkg.sv */
`default_nettype none
package md5_pkg;

    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = 5;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_LIMIT   = 6'd56;
    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;
    localparam logic [1:0] LAST_LANE   = 2'd3;
    localparam logic [1:0] LAST_INDEX  = 2'd3;
    localparam logic [5:0] LAST_ROUND  = 6'd63;

    // round groups of the compression
    localparam logic [1:0] PHASE_F = 2'd0;
    localparam logic [1:0] PHASE_G = 2'd1;
    localparam logic [1:0] PHASE_H = 2'd2;
    localparam logic [1:0] PHASE_I = 2'd3;

    localparam logic [31:0] MD5_INIT [0:3] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [0:15] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic bank;
        logic last_blk;
    } t_blk_cmd;

    typedef struct packed {
        logic     valid;
        t_blk_cmd cmd;
    } t_cmd_push;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    // message word used by a round
    function automatic logic [3:0] md5_msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        case (rnd[5:4])
            PHASE_F: idx = r4;
            PHASE_G: idx = 4'(r4 * 4'd5 + 4'd1);
            PHASE_H: idx = 4'(r4 * 4'd3 + 4'd5);
            PHASE_I: idx = 4'(r4 * 4'd7);
            default: idx = r4;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] md5_mix(input logic [1:0] phase,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            PHASE_F: f = (b & c) | (~b & d);
            PHASE_G: f = (b & d) | (c & ~d);
            PHASE_H: f = b ^ c ^ d;
            PHASE_I: f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

/* sv/md5_ram.sv */
`default_nettype none
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* sv/md5_front.sv */
`default_nettype none
module md5_front
    import md5_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_msg_byte,
    input  wire logic              i_has_byte,
    input  wire logic              i_end_of_message,
    output logic                   o_ram_we,
    output logic      [RAM_AW-1:0] o_ram_waddr,
    output logic      [31:0]       o_ram_wdata,
    output t_cmd_push              o_cmd,
    input  wire t_release          i_release
);

    typedef enum logic [1:0] {
        F_TAKE = 2'b01,
        F_PAD  = 2'b10
    } t_front_state;

    t_front_state r_state, n_state;
    logic         r_bank, n_bank;
    logic [1:0]   r_busy, n_busy;
    logic [5:0]   r_fill, n_fill;
    logic [31:0]  r_word, n_word;
    logic [63:0]  r_bitlen, n_bitlen;
    logic [3:0]   r_widx, n_widx;
    logic         r_mark, n_mark;
    logic         r_len_here, n_len_here;

    logic         take;
    logic [4:0]   lane_sh;
    logic [31:0]  word_base;
    logic [31:0]  mark_word;

    assign full    = !(r_state == F_TAKE && !r_busy[r_bank]);
    assign take    = push && !full;
    assign lane_sh = {r_fill[1:0], 3'b000};

    // upper lanes of a fresh word start out clear
    assign word_base = (r_fill[1:0] == 2'd0) ? 32'd0 : r_word;
    assign mark_word = word_base | (32'(PAD_BYTE) << lane_sh);

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_fill      = r_fill;
        n_word      = r_word;
        n_bitlen    = r_bitlen;
        n_widx      = r_widx;
        n_mark      = r_mark;
        n_len_here  = r_len_here;
        o_ram_we    = 1'b0;
        o_ram_waddr = {r_bank, r_widx};
        o_ram_wdata = 32'd0;
        o_cmd       = '0;

        case (r_state)
            F_TAKE: begin
                if (take) begin
                    if (i_has_byte) begin
                        n_word   = word_base | (32'(i_msg_byte) << lane_sh);
                        n_fill   = r_fill + 6'd1;
                        n_bitlen = r_bitlen + 64'd8;
                        if (r_fill[1:0] == LAST_LANE) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = {r_bank, r_fill[5:2]};
                            o_ram_wdata = n_word;
                        end
                        if (r_fill == LAST_BYTE) begin
                            o_cmd.valid        = 1'b1;
                            o_cmd.cmd.bank     = r_bank;
                            o_cmd.cmd.last_blk = 1'b0;
                            n_bank             = !r_bank;
                        end
                    end
                    if (i_end_of_message) begin
                        n_state    = F_PAD;
                        n_mark     = 1'b1;
                        n_widx     = n_fill[5:2];
                        n_len_here = (n_fill < LEN_LIMIT);
                    end
                end
            end
            F_PAD: begin
                if (!r_busy[r_bank]) begin
                    o_ram_we = 1'b1;
                    if (r_mark) begin
                        o_ram_wdata = mark_word;
                    end else if (r_len_here && r_widx == LEN_LO_WORD) begin
                        o_ram_wdata = r_bitlen[31:0];
                    end else if (r_len_here && r_widx == LEN_HI_WORD) begin
                        o_ram_wdata = r_bitlen[63:32];
                    end
                    n_mark = 1'b0;
                    if (r_widx == LEN_HI_WORD) begin
                        o_cmd.valid        = 1'b1;
                        o_cmd.cmd.bank     = r_bank;
                        o_cmd.cmd.last_blk = r_len_here;
                        n_bank             = !r_bank;
                        if (r_len_here) begin
                            n_state  = F_TAKE;
                            n_fill   = 6'd0;
                            n_bitlen = 64'd0;
                        end else begin
                            // length did not fit: a second all-zero block carries it
                            n_len_here = 1'b1;
                            n_widx     = 4'd0;
                        end
                    end else begin
                        n_widx = r_widx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = F_TAKE;
            end
        endcase

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_cmd.valid) begin
            n_busy[o_cmd.cmd.bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_TAKE;
            r_bank   <= 1'b0;
            r_busy   <= 2'b00;
            r_fill   <= 6'd0;
            r_bitlen <= 64'd0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
        end
        r_word     <= n_word;
        r_widx     <= n_widx;
        r_mark     <= n_mark;
        r_len_here <= n_len_here;
    end

endmodule
`default_nettype wire

/* sv/md5_core.sv */
`default_nettype none
module md5_core
    import md5_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd_push         i_cmd,
    output t_release               o_release,
    output logic      [RAM_AW-1:0] o_ram_raddr,
    input  wire logic [31:0]       i_ram_rdata,
    output logic                   empty,
    input  wire logic              pop,
    output logic      [31:0]       o_digest_word,
    output logic      [1:0]        o_word_index,
    output logic                   o_last_word
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_PRE   = 5'b00010,
        B_ROUND = 5'b00100,
        B_ADD   = 5'b01000,
        B_EMIT  = 5'b10000
    } t_core_state;

    t_core_state r_state, n_state;
    t_blk_cmd    r_cur, n_cur;
    logic [5:0]  r_round, n_round;
    logic [31:0] r_km, n_km;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [1:0]  r_emit, n_emit;
    logic [31:0] r_chain [0:3];

    // block command queue
    t_blk_cmd    r_q [0:1];
    logic        r_q_wp, r_q_rp;
    logic [1:0]  r_q_cnt;
    logic        q_pop;
    t_blk_cmd    q_head;

    // result queue
    logic [31:0] r_o_word [0:3];
    logic [1:0]  r_o_idx [0:3];
    logic [1:0]  r_o_wp, r_o_rp;
    logic [2:0]  r_o_cnt;
    logic        o_push, o_pop, o_full;

    logic        chain_add, chain_init;
    logic [5:0]  rnd_next, rnd_next2;
    logic [31:0] mix, sum;
    logic [63:0] rot2;
    logic [31:0] new_b;

    assign q_head    = r_q[r_q_rp];
    assign rnd_next  = r_round + 6'd1;
    assign rnd_next2 = r_round + 6'd2;

    assign mix   = md5_mix(r_round[5:4], r_b, r_c, r_d);
    assign sum   = r_a + mix + r_km;
    assign rot2  = {sum, sum} << MD5_S[{r_round[5:4], r_round[1:0]}];
    assign new_b = r_b + rot2[63:32];

    assign o_full = (r_o_cnt == 3'd4);
    assign empty  = (r_o_cnt == 3'd0);
    assign o_pop  = pop && !empty;

    assign o_digest_word = r_o_word[r_o_rp];
    assign o_word_index  = r_o_idx[r_o_rp];
    assign o_last_word   = (r_o_idx[r_o_rp] == LAST_INDEX);

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_round     = r_round;
        n_km        = r_km;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_emit      = r_emit;
        q_pop       = 1'b0;
        o_push      = 1'b0;
        chain_add   = 1'b0;
        chain_init  = 1'b0;
        o_release   = '0;
        o_ram_raddr = {r_cur.bank, md5_msg_index(6'd0)};

        case (r_state)
            B_IDLE: begin
                o_ram_raddr = {q_head.bank, md5_msg_index(6'd0)};
                if (r_q_cnt != 2'd0) begin
                    n_cur   = q_head;
                    n_a     = r_chain[0];
                    n_b     = r_chain[1];
                    n_c     = r_chain[2];
                    n_d     = r_chain[3];
                    n_state = B_PRE;
                end
            end
            B_PRE: begin
                // read data runs one round ahead of the round logic
                o_ram_raddr = {r_cur.bank, md5_msg_index(6'd1)};
                n_km        = MD5_K[0] + i_ram_rdata;
                n_round     = 6'd0;
                n_state     = B_ROUND;
            end
            B_ROUND: begin
                o_ram_raddr = {r_cur.bank, md5_msg_index(rnd_next2)};
                n_km        = MD5_K[rnd_next] + i_ram_rdata;
                n_a         = r_d;
                n_d         = r_c;
                n_c         = r_b;
                n_b         = new_b;
                n_round     = rnd_next;
                if (r_round == LAST_ROUND) begin
                    n_state = B_ADD;
                end
            end
            B_ADD: begin
                chain_add       = 1'b1;
                q_pop           = 1'b1;
                o_release.valid = 1'b1;
                o_release.bank  = r_cur.bank;
                n_emit          = 2'd0;
                n_state         = r_cur.last_blk ? B_EMIT : B_IDLE;
            end
            B_EMIT: begin
                if (!o_full) begin
                    o_push = 1'b1;
                    n_emit = r_emit + 2'd1;
                    if (r_emit == LAST_INDEX) begin
                        chain_init = 1'b1;
                        n_state    = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= 2'd0;
            r_o_wp  <= 2'd0;
            r_o_rp  <= 2'd0;
            r_o_cnt <= 3'd0;
            r_chain <= MD5_INIT;
        end else begin
            r_state <= n_state;
            if (i_cmd.valid) begin
                r_q_wp <= !r_q_wp;
            end
            if (q_pop) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + 2'(i_cmd.valid) - 2'(q_pop);
            if (o_push) begin
                r_o_wp <= r_o_wp + 2'd1;
            end
            if (o_pop) begin
                r_o_rp <= r_o_rp + 2'd1;
            end
            r_o_cnt <= r_o_cnt + 3'(o_push) - 3'(o_pop);
            if (chain_add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end else if (chain_init) begin
                r_chain <= MD5_INIT;
            end
        end
        r_cur   <= n_cur;
        r_round <= n_round;
        r_km    <= n_km;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_emit  <= n_emit;
        if (i_cmd.valid) begin
            r_q[r_q_wp] <= i_cmd.cmd;
        end
        if (o_push) begin
            r_o_word[r_o_wp] <= r_chain[r_emit];
            r_o_idx[r_o_wp]  <= r_emit;
        end
    end

endmodule
`default_nettype wire

/* sv/md5_message_digest.sv */
// md5 digest engine, one message byte per input transaction
//
// input side behaves as a queue: a transaction is taken when push is high
// and full is low. i_has_byte qualifies i_msg_byte; i_end_of_message closes
// the message (with or without a byte), pads it and requests the digest.
// result side behaves as a queue: while empty is low the oldest digest word
// is on o_digest_word / o_word_index / o_last_word; pop takes it. each
// message gives four words, A first, o_last_word on D.
//
// bytes are packed at one per cycle while full is low into one of two
// 16-word banks of a 32-word ram. a full bank goes through a two-entry
// command queue to the compression unit, which works a 64-byte block in
// steps (address, read prefetch, 64 rounds, chaining add) while the other
// bank fills. full is high while the bank being filled still waits on
// compression, and during padding. end of message writes the padding and
// length words into one or two blocks, and the four words leave one per
// cycle after the last block while the result queue has room.
// a stalled result queue (four entries) holds the compression unit, which
// in turn backs up into full. reset clears the queues and chaining values;
// no clearing pass is needed.
`default_nettype none
module md5_message_digest
    import md5_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             empty,
    input  wire logic        pop,
    output logic      [31:0] o_digest_word,
    output logic      [1:0]  o_word_index,
    output logic             o_last_word
);

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    t_cmd_push         blk_cmd;
    t_release          blk_release;

    md5_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_msg_byte       (i_msg_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_cmd            (blk_cmd),
        .i_release        (blk_release)
    );

    md5_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    md5_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (blk_cmd),
        .o_release     (blk_release),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .empty         (empty),
        .pop           (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
`default_nettype wire

/* sv/md5_message_digest_chk.sv */
`default_nettype none
module md5_message_digest_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_digest_word,
    input wire logic [1:0]  o_word_index,
    input wire logic        o_last_word
);

    // queues come up clear and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == 2'd3)))
        else $error("last word flag does not match word index");

    // digest words of a message leave in order A to D
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_word_index != 2'd3) |=>
            (empty || o_word_index == 2'($past(o_word_index) + 2'd1)))
        else $error("digest word out of order");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("waiting result changed");

endmodule

bind md5_message_digest md5_message_digest_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
`default_nettype wire

/* verif/md5_message_digest_tb.sv */
`timescale 1ns / 1ps

module md5_message_digest_tb;
    import md5_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_ITEMS  = 60;

    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int          LEN_SLOT = 56;

    localparam logic [31:0] CHAIN_SEED [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                4, 11, 16, 23, 6, 10, 15, 21};

    // message lengths that hit the padding boundaries, one per idling phase
    localparam int EDGE_LEN [4] = '{56, 55, 64, 57};
    localparam int SEND_IDLE [4] = '{0, 80, 0, 16};
    localparam int RECV_IDLE [4] = '{0, 0, 80, 16};

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    class t_md5_scoreboard;
        logic [31:0]  chain [4];
        logic [31:0]  blk [16];
        logic [5:0]   fill;
        logic [63:0]  msg_bits;
        t_digest_word digests_due [$];
        int           errors;

        function new();
            errors = 0;
            foreach (blk[k]) blk[k] = '0;
            restart_message();
        endfunction

        function void restart_message();
            foreach (chain[k]) chain[k] = CHAIN_SEED[k];
            fill     = '0;
            msg_bits = '0;
        endfunction

        function void set_byte(int pos, logic [7:0] v);
            blk[pos / 4][8 * (pos % 4) +: 8] = v;
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t, sum;
            logic [1:0]  ph;
            int          w, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++) begin
                ph = 2'(r / 16);
                case (ph)
                    PHASE_F: begin
                        f = (b & c) | (~b & d);
                        w = r % 16;
                    end
                    PHASE_G: begin
                        f = (b & d) | (c & ~d);
                        w = (5 * r + 1) % 16;
                    end
                    PHASE_H: begin
                        f = b ^ c ^ d;
                        w = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        w = (7 * r) % 16;
                    end
                endcase
                s   = ROT[ph * 4 + r % 4];
                sum = a + f + ROUND_K[r] + blk[w];
                t   = d;
                d   = c;
                c   = b;
                b   = b + ((sum << s) | (sum >> (32 - s)));
                a   = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_item(logic [7:0] b, logic has, logic eom);
            t_digest_word dw;
            if (has) begin
                set_byte(fill, b);
                fill++;
                msg_bits += 64'd8;
                if (fill == 0) compress();
            end
            if (!eom) return;
            set_byte(fill, PAD_MARK);
            for (int p = fill + 1; p < 64; p++) set_byte(p, 8'h00);
            // no room for the length: it goes into an extra block
            if (fill >= LEN_SLOT) begin
                compress();
                foreach (blk[k]) blk[k] = '0;
            end
            blk[14] = msg_bits[31:0];
            blk[15] = msg_bits[63:32];
            compress();
            for (int k = 0; k < 4; k++) begin
                dw.word  = chain[k];
                dw.index = 2'(k);
                dw.last  = (k == 3);
                digests_due.push_back(dw);
            end
            restart_message();
        endfunction

        function void check_word(logic [31:0] word, logic [1:0] index, logic last);
            t_digest_word want;
            if (digests_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest word %08h index %0d last %0d",
                             word, index, last);
                return;
            end
            want = digests_due.pop_front();
            if (want.word !== word || want.index !== index || want.last !== last) begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: expected %08h/%0d/%0d, got %08h/%0d/%0d",
                             want.word, want.index, want.last, word, index, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_msg_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int items_sent = 0;

    t_md5_scoreboard digests = new();

    md5_message_digest DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_msg_byte       (i_msg_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            digests.check_word(o_digest_word, o_word_index, o_last_word);
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("DONE: errors detected");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [7:0] b, input logic has, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push             <= 1'b1;
        i_msg_byte       <= b;
        i_has_byte       <= has;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        digests.note_item(b, has, eom);
        if (has || eom) items_sent++;
        @(negedge i_clk);
    endtask

    // noise transactions carry neither a byte nor an end
    task automatic send_message(input int len, input bit tail_byte, input int noise_pct);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, tail_byte && i == len - 1);
        end
        if (!tail_byte || len == 0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // sender waits for every digest word, then switches idling
    task automatic settle_phase(input int send_pct, input int recv_pct);
        push <= 1'b0;
        @(posedge i_clk);
        while (digests.digests_due.size() != 0) @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge i_clk);
    endtask

    initial begin
        int start;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        settle_phase(0, 0);

        // long result stall while messages keep coming, to back up into full
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        repeat (6) send_message($urandom_range(3, 8), 1'($urandom_range(1)), 0);

        for (int ph = 0; ph < 4; ph++) begin
            settle_phase(SEND_IDLE[ph], RECV_IDLE[ph]);
            start = items_sent;
            send_message(EDGE_LEN[ph], 1'($urandom_range(1)), 5);
            while (items_sent - start < PHASE_ITEMS)
                send_message($urandom_range(0, 12), 1'($urandom_range(1)), 10);
        end

        settle_phase(0, 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digests.errors == 0 && digests.digests_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
